>>> hw/rtl/tle_pkg.sv
// Shared types and constants for the terminal line editor.
`default_nettype none
package tle_pkg;

  localparam int unsigned LINE_BYTES_DEF = 32;

  localparam int unsigned LIMIT_W  = 6;
  localparam int unsigned LENGTH_W = 5;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;
  localparam logic [0:0]         REG_LINE_LIMIT = 1'b0;

  localparam logic [1:0] DEST_ECHO = 2'd0;
  localparam logic [1:0] DEST_LINE = 2'd1;
  localparam logic [1:0] DEST_DONE = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]          dest;
    logic [7:0]          data_byte;
    logic [LENGTH_W-1:0] line_length;
    logic                last;
  } res_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/tle_chan_if.sv
// Valid/ready channel carrying one item per handshake.
`default_nettype none
interface tle_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tle_line_ram.sv
// Line store: one write port, one registered read port.
`default_nettype none
module tle_line_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);
  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/terminal_line_editor.sv
// Terminal line editor: echoes and edits received bytes, streams out finished lines.
// Flow: an accepted item is registered into the sequencer state, and each of its results is then
//   registered in the output register; the input is not ready again until the sequencer is idle.
//   Results: ignored byte none, printable 1, erase 3, line end fill+3 (up to LINE_BYTES+2);
//   the line readout issues one store read per result from the single read port.
// Reset: asynchronous, clears fill index, sequencer and output valid; line_limit goes to 32.
//   Store contents stay undefined until written; there is no clearing pass.
`default_nettype none
module terminal_line_editor #(
  parameter int unsigned LINE_BYTES = tle_pkg::LINE_BYTES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  tle_chan_if.sink                          rx_chan_i,
  tle_chan_if.source                        res_chan_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tle_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tle_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tle_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);
  import tle_pkg::*;

  localparam int unsigned IDXW  = $clog2(LINE_BYTES);
  localparam int unsigned CW    = (IDXW + 1 > LIMIT_W + 1) ? IDXW + 1 : LIMIT_W + 1;
  localparam int unsigned LENXW = (IDXW > LENGTH_W) ? IDXW : LENGTH_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ECHO, S_BS0, S_BS1, S_BS2, S_CR, S_LF, S_LINE, S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic [IDXW-1:0]    fill_q, fill_d;
  logic [IDXW-1:0]    len_q, len_d;
  logic [IDXW-1:0]    cnt_q, cnt_d;
  logic [7:0]         char_q, char_d;
  logic               out_valid_q, out_valid_d;
  res_item_t          out_q, out_d;

  logic               accept, slot_free, emit;
  logic [7:0]         c;
  logic               is_eol, is_erase, is_print;
  logic [CW-1:0]      lim_c, max_chars;
  logic               room;
  logic               wr_en, rd_en;
  logic [IDXW-1:0]    rd_addr;
  logic [7:0]         rd_data;
  logic [LENXW-1:0]   len_ext;
  logic [IDXW:0]      cnt_next;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && (paddr[2] == REG_LINE_LIMIT)) begin
      limit_d = pwdata[LIMIT_W-1:0];
    end
    prdata = '0;
    if (paddr[2] == REG_LINE_LIMIT) begin
      prdata = {{(PDATA_W-LIMIT_W){1'b0}}, limit_q};
    end
  end

  // Classification of the incoming byte
  assign c        = rx_chan_i.payload.rx_byte;
  assign is_eol   = (c == CH_CR) || (c == CH_LF);
  assign is_erase = (c == CH_BS) || (c == CH_DEL);
  assign is_print = (c >= CH_SPACE) && (c <= CH_TILDE);

  // Clamp limit to 1..LINE_BYTES; keep at most limit-1 characters
  always_comb begin
    lim_c = CW'(limit_q);
    if (lim_c == '0) begin
      lim_c = CW'(1);
    end else if (lim_c > CW'(LINE_BYTES)) begin
      lim_c = CW'(LINE_BYTES);
    end
    max_chars = lim_c - CW'(1);
  end
  assign room = CW'(fill_q) < max_chars;

  assign rx_chan_i.ready  = (state_q == S_IDLE);
  assign accept           = rx_chan_i.valid && rx_chan_i.ready;
  assign slot_free        = !out_valid_q || res_chan_o.ready;
  assign res_chan_o.valid   = out_valid_q;
  assign res_chan_o.payload = out_q;

  assign len_ext  = LENXW'(len_q);
  assign cnt_next = {1'b0, cnt_q} + (IDXW+1)'(1);

  assign wr_en = accept && is_print && room;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    char_d      = char_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_chan_o.ready;
    emit        = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cnt_next[IDXW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          char_d = c;
          if (is_eol) begin
            len_d   = fill_q;
            fill_d  = '0;
            cnt_d   = '0;
            state_d = S_CR;
          end else if (is_erase) begin
            if (fill_q != '0) begin
              fill_d  = fill_q - IDXW'(1);
              state_d = S_BS0;
            end
          end else if (is_print && room) begin
            fill_d  = fill_q + IDXW'(1);
            state_d = S_ECHO;
          end
        end
      end
      S_ECHO: begin
        if (slot_free) begin
          emit    = 1'b1;
          out_d   = '{dest: DEST_ECHO, data_byte: char_q, line_length: '0, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_BS0: begin
        if (slot_free) begin
          emit    = 1'b1;
          out_d   = '{dest: DEST_ECHO, data_byte: CH_BS, line_length: '0, last: 1'b0};
          state_d = S_BS1;
        end
      end
      S_BS1: begin
        if (slot_free) begin
          emit    = 1'b1;
          out_d   = '{dest: DEST_ECHO, data_byte: CH_SPACE, line_length: '0, last: 1'b0};
          state_d = S_BS2;
        end
      end
      S_BS2: begin
        if (slot_free) begin
          emit    = 1'b1;
          out_d   = '{dest: DEST_ECHO, data_byte: CH_BS, line_length: '0, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_CR: begin
        if (slot_free) begin
          emit    = 1'b1;
          out_d   = '{dest: DEST_ECHO, data_byte: CH_CR, line_length: '0, last: 1'b0};
          state_d = S_LF;
        end
      end
      S_LF: begin
        if (slot_free) begin
          emit    = 1'b1;
          out_d   = '{dest: DEST_ECHO, data_byte: CH_LF, line_length: '0, last: 1'b0};
          // prefetch the first line byte
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = (len_q == '0) ? S_DONE : S_LINE;
        end
      end
      S_LINE: begin
        // read data holds until the next read, so a stall keeps it
        if (slot_free) begin
          emit  = 1'b1;
          out_d = '{dest: DEST_LINE, data_byte: rd_data, line_length: '0, last: 1'b0};
          cnt_d = cnt_next[IDXW-1:0];
          if (cnt_next < {1'b0, len_q}) begin
            rd_en = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          emit    = 1'b1;
          out_d   = '{dest: DEST_DONE, data_byte: 8'h00,
                      line_length: len_ext[LENGTH_W-1:0], last: 1'b1};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= LIMIT_RESET;
      fill_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      char_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      char_q      <= char_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  tle_line_ram #(
    .DEPTH (LINE_BYTES),
    .AW    (IDXW)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill_q),
    .wr_data_i (c),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );
endmodule
`default_nettype wire

>>> test/terminal_line_editor_test.sv
// Self-checking testbench for terminal_line_editor: predicts echo and line output per byte.
`timescale 1ns / 1ps
module terminal_line_editor_test;
  import tle_pkg::*;

  localparam int LINE_BYTES      = LINE_BYTES_DEF;
  localparam int SETTLE_CYCLES   = 6;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASES          = 8;
  localparam int PHASE_QUOTA     = 41;
  localparam int TX_SIDE         = 0;
  localparam int RX_SIDE         = 1;

  localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * REG_LINE_LIMIT);
  localparam logic [PADDR_W-1:0] SPARE_ADDR = LIMIT_ADDR + PADDR_W'(4);

  logic clk = 1'b0;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tle_chan_if #(.payload_t(rx_item_t))  rx_chan ();
  tle_chan_if #(.payload_t(res_item_t)) res_chan ();

  terminal_line_editor i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx_chan_i  (rx_chan),
    .res_chan_o (res_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  // Shadow of the editor state
  logic [7:0]         line_copy [LINE_BYTES];
  int                 fill_count = 0;
  logic [LIMIT_W-1:0] line_limit = LIMIT_RESET;
  res_item_t          editor_out_q[$];

  int errors        = 0;
  int bytes_sent    = 0;
  int active_bytes  = 0;
  int results_seen  = 0;
  int lines_done    = 0;
  int quiet_cycles  = 0;
  int run_left [2]  = '{0, 0};
  bit run_calm [2]  = '{0, 0};

  // Wait cycles come in stretches, some of them with no waiting at all.
  function automatic int draw_wait(input int side);
    if (run_left[side] == 0) begin
      run_left[side] = $urandom_range(4, 24);
      run_calm[side] = ($urandom_range(0, 3) == 0);
    end
    run_left[side]--;
    return run_calm[side] ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic int max_chars();
    int lim;
    lim = int'(line_limit);
    if (lim < 1) lim = 1;
    if (lim > LINE_BYTES) lim = LINE_BYTES;
    return lim - 1;
  endfunction

  function automatic res_item_t make_result(input logic [1:0] dest, input logic [7:0] data,
                                            input logic [LENGTH_W-1:0] len);
    res_item_t r;
    r.dest        = dest;
    r.data_byte   = data;
    r.line_length = len;
    r.last        = 1'b0;
    return r;
  endfunction

  // Apply one received byte to the shadow line and queue the output it causes.
  function automatic int edit_line(input logic [7:0] c);
    res_item_t batch[$];
    if (c == CH_CR || c == CH_LF) begin
      batch.push_back(make_result(DEST_ECHO, CH_CR, '0));
      batch.push_back(make_result(DEST_ECHO, CH_LF, '0));
      for (int k = 0; k < fill_count; k++)
        batch.push_back(make_result(DEST_LINE, line_copy[k], '0));
      batch.push_back(make_result(DEST_DONE, 8'h00, LENGTH_W'(fill_count)));
      fill_count = 0;
    end else if (c == CH_BS || c == CH_DEL) begin
      if (fill_count > 0) begin
        fill_count--;
        batch.push_back(make_result(DEST_ECHO, CH_BS, '0));
        batch.push_back(make_result(DEST_ECHO, CH_SPACE, '0));
        batch.push_back(make_result(DEST_ECHO, CH_BS, '0));
      end
    end else if (c >= CH_SPACE && c <= CH_TILDE) begin
      if (fill_count < max_chars()) begin
        line_copy[fill_count] = c;
        fill_count++;
        batch.push_back(make_result(DEST_ECHO, c, '0));
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) editor_out_q.push_back(batch[k]);
    return batch.size();
  endfunction

  // Leaves valid high after the handshake so that back-to-back items need no gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(TX_SIDE);
    if (gap > 0) begin
      rx_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_chan.valid           <= 1'b1;
    rx_chan.payload.rx_byte <= b;
    @(posedge clk);
    while (!rx_chan.ready) @(posedge clk);
    bytes_sent++;
    if (edit_line(b) > 0) active_bytes++;
  endtask

  // Drop valid, drain all expected output, then allow for an ignored byte still in flight.
  task automatic settle_editor();
    rx_chan.valid <= 1'b0;
    do @(posedge clk); while (editor_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == LIMIT_ADDR) line_limit = data[LIMIT_W-1:0];
    @(posedge clk);
  endtask

  task automatic send_random_line();
    int span;
    span = $urandom_range(0, max_chars() + 3);
    for (int k = 0; k < span; k++) begin
      if ($urandom_range(0, 7) == 0) send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
      else send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
    end
    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 2) == 0) send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_basic_editing();
    send_byte(CH_SPACE);
    send_byte(CH_TILDE);
    send_byte(8'h1F);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h09);
    send_byte(CH_BS);
    send_byte(8'h41);
    send_byte(CH_DEL);
    send_byte(CH_CR);
    // empty line, then erase with nothing to erase
    send_byte(CH_LF);
    send_byte(CH_BS);
    send_byte(CH_DEL);
  endtask

  task automatic test_limit_edges();
    settle_editor();
    write_reg(SPARE_ADDR, 32'h0000_0001);
    write_reg(LIMIT_ADDR, 32'd3);
    // two characters fit; the third is dropped, and after an erase one more fits
    send_byte(8'h78);
    send_byte(8'h79);
    send_byte(8'h7A);
    send_byte(CH_BS);
    send_byte(8'h77);
    send_byte(CH_LF);
    settle_editor();
    write_reg(LIMIT_ADDR, 32'd0);
    send_byte(8'h21);
    send_byte(CH_CR);
  endtask

  task automatic test_random_traffic();
    logic [PDATA_W-1:0] phase_word [PHASES];
    int target;
    phase_word = '{32'd63, 32'd0, 32'd1, 32'd2, 32'd31, 32'd33, $urandom(), 32'd32};
    foreach (phase_word[p]) begin
      settle_editor();
      write_reg(LIMIT_ADDR, phase_word[p]);
      target = bytes_sent + PHASE_QUOTA;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 4) != 0) send_random_line();
        else send_noise();
      end
    end
  endtask

  // Result side: random stalls, compare each accepted item with the oldest expectation.
  initial begin : result_sink
    int stall;
    res_item_t want;
    res_item_t got;
    stall = 0;
    res_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (res_chan.valid && res_chan.ready) begin
        got = res_chan.payload;
        results_seen++;
        if (editor_out_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result dest=%0d data=%02h len=%0d last=%0b", $time,
                   got.dest, got.data_byte, got.line_length, got.last);
        end else begin
          want = editor_out_q.pop_front();
          if (want.dest === DEST_DONE) lines_done++;
          if (got.dest !== want.dest || got.data_byte !== want.data_byte ||
              got.line_length !== want.line_length || got.last !== want.last) begin
            errors++;
            $display("%0t: mismatch expected dest=%0d data=%02h len=%0d last=%0b,",
                     $time, want.dest, want.data_byte, want.line_length, want.last,
                     " got dest=%0d data=%02h len=%0d last=%0b",
                     got.dest, got.data_byte, got.line_length, got.last);
          end
        end
        stall = draw_wait(RX_SIDE);
        if (stall > 0) res_chan.ready <= 1'b0;
      end else if (!res_chan.ready) begin
        if (stall > 0) stall--;
        if (stall == 0) res_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((rx_chan.valid && rx_chan.ready) || (res_chan.valid && res_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_CYCLES);
    $display("%0t: no handshake for %0d cycles, %0d results still expected", $time,
             WATCHDOG_CYCLES, editor_out_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_flow
    rst_n                   = 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    rx_chan.valid           <= 1'b0;
    rx_chan.payload.rx_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_editing();
    test_limit_edges();
    test_random_traffic();
    settle_editor();

    $display("Sent %0d bytes (%0d with output); checked %0d results over %0d finished lines.",
             bytes_sent, active_bytes, results_seen, lines_done);
    $display("line_limit runs: reset, 3, 0, 63, 0, 1, 2, 31, 33, random word, 32; errors: %0d",
             errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tle_pkg.sv
hw/rtl/tle_chan_if.sv
hw/rtl/tle_line_ram.sv
hw/rtl/terminal_line_editor.sv
test/terminal_line_editor_test.sv
